// File: rtl/core/gwwb_pkg.sv
// Package with the widths, constants and sequencer states of the gray-world white balance block.
package gwwb_pkg;

  // Channel value, running sum and derived widths.
  localparam int PIX_W   = 8;
  localparam int SUM_W   = 28;
  localparam int TOT_W   = SUM_W + 2;          // sum of three channel sums
  localparam int NUM_W   = PIX_W + TOT_W;      // pixel value times total
  localparam int DEN_W   = SUM_W + 2;          // three times one channel sum
  localparam int QBITS   = 10;                 // quotient bits; the top one flags saturation
  localparam int UNIT_W  = DEN_W + QBITS - 1;  // width of the shared compare and subtract unit
  localparam int STEP_W  = 4;
  localparam int CH_W    = 2;

  localparam logic [STEP_W-1:0] LAST_STEP    = STEP_W'(QBITS - 1);
  localparam logic [CH_W-1:0]   LAST_CHANNEL = CH_W'(2);
  localparam logic [PIX_W-1:0]  PIX_MAX      = '1;

  // Input mode codes.
  localparam logic MODE_GATHER = 1'b0;
  localparam logic MODE_APPLY  = 1'b1;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TOTAL,
    ST_MUL,
    ST_DIV,
    ST_RND,
    ST_DONE
  } state_t;

endpackage

// File: rtl/core/gray_world_white_balance_top.sv
// Top level of the gray-world white balance block with its sequencer and shared divider unit.
//
// Usage: pixels arrive on the input channel (in_valid / in_stall) with a mode bit.
// A gather transaction (mode 0) adds the pixel into three saturating running sums
// in the cycle it is accepted and produces no result; with frame_end set, the
// updated sums are latched as frame sums and the running sums are cleared.
// An apply transaction (mode 1) produces one balanced pixel on the output channel
// (out_valid / out_stall). The three frame sums are added first. Each channel then
// goes through a multiply step, ten restoring division steps on one shared
// 39-bit compare and subtract unit, and a rounding step on the same unit. The
// result register is loaded after the last channel, and only then is the next
// pixel accepted. Gather pixels are taken one per cycle while no apply pixel is
// under work.
// The result register lets a new transaction be accepted while a result still
// waits; a finished apply result holds the sequencer until the output register
// is free. Reset (rst, synchronous) clears all sums and drops out_valid.
module gray_world_white_balance_top
  import gwwb_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             mode,
  input  logic [PIX_W-1:0] pixel_blue,
  input  logic [PIX_W-1:0] pixel_green,
  input  logic [PIX_W-1:0] pixel_red,
  input  logic             frame_end,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [PIX_W-1:0] balanced_blue,
  output logic [PIX_W-1:0] balanced_green,
  output logic [PIX_W-1:0] balanced_red
);

  state_t state, state_next;

  // Statistics.
  logic [SUM_W-1:0] run_b, run_g, run_r;
  logic [SUM_W-1:0] frm_b, frm_g, frm_r;

  // Working registers for one apply pixel.
  logic [PIX_W-1:0]  px_b, px_g, px_r;
  logic [TOT_W-1:0]  total;
  logic [CH_W-1:0]   ch;
  logic [STEP_W-1:0] step;
  logic [NUM_W-1:0]  rem;
  logic [UNIT_W-1:0] dsh;
  logic [DEN_W-1:0]  den;
  logic              den_zero;
  logic [QBITS-1:0]  quo;
  logic [PIX_W-1:0]  res_b, res_g, res_r;

  logic in_acc, out_free;
  logic [SUM_W:0] add_b, add_g, add_r;
  logic [SUM_W-1:0] sat_b, sat_g, sat_r;
  logic [PIX_W-1:0] cur_px;
  logic [SUM_W-1:0] cur_sum;
  logic [UNIT_W-1:0] unit_a, unit_b, unit_diff;
  logic unit_ge, unit_eq;
  logic round_up;
  logic [QBITS-1:0] quo_rnd;
  logic [PIX_W-1:0] ch_res;

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Saturating adds of the incoming pixel into the running sums.
  always_comb begin
    add_b = {1'b0, run_b} + (SUM_W+1)'(pixel_blue);
    add_g = {1'b0, run_g} + (SUM_W+1)'(pixel_green);
    add_r = {1'b0, run_r} + (SUM_W+1)'(pixel_red);
    sat_b = add_b[SUM_W] ? '1 : add_b[SUM_W-1:0];
    sat_g = add_g[SUM_W] ? '1 : add_g[SUM_W-1:0];
    sat_r = add_r[SUM_W] ? '1 : add_r[SUM_W-1:0];
  end

  // Pixel value and frame sum of the channel under work.
  always_comb begin
    case (ch)
      2'd0: begin
        cur_px  = px_b;
        cur_sum = frm_b;
      end
      2'd1: begin
        cur_px  = px_g;
        cur_sum = frm_g;
      end
      default: begin
        cur_px  = px_r;
        cur_sum = frm_r;
      end
    endcase
  end

  // Next state of the sequencer.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_acc && mode == MODE_APPLY) state_next = ST_TOTAL;
      ST_TOTAL: state_next = ST_MUL;
      ST_MUL:   state_next = ST_DIV;
      ST_DIV:   if (step == '0) state_next = ST_RND;
      ST_RND:   state_next = (ch == LAST_CHANNEL) ? ST_DONE : ST_MUL;
      ST_DONE:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Operand selection for the shared unit and the handshake output.
  always_comb begin
    in_stall = (state != ST_IDLE);
    case (state)
      ST_RND: begin
        unit_a = UNIT_W'({rem[DEN_W-1:0], 1'b0});
        unit_b = UNIT_W'(den);
      end
      default: begin
        unit_a = UNIT_W'(rem);
        unit_b = dsh;
      end
    endcase
  end

  // Shared compare and subtract unit.
  assign unit_diff = unit_a - unit_b;
  assign unit_ge   = (unit_a >= unit_b);
  assign unit_eq   = (unit_a == unit_b);

  // Rounding, half to even, and saturation of one channel.
  always_comb begin
    round_up = (unit_ge && !unit_eq) || (unit_eq && quo[0]);
    quo_rnd  = {1'b0, quo[QBITS-2:0]} + QBITS'(round_up);
    if (den_zero) begin
      ch_res = '0;
    end else if (quo[QBITS-1] || quo_rnd > QBITS'(PIX_MAX)) begin
      ch_res = PIX_MAX;
    end else begin
      ch_res = quo_rnd[PIX_W-1:0];
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      run_b     <= '0;
      run_g     <= '0;
      run_r     <= '0;
      frm_b     <= '0;
      frm_g     <= '0;
      frm_r     <= '0;
    end else begin
      state <= state_next;
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (in_acc && mode == MODE_GATHER) begin
        if (frame_end) begin
          frm_b <= sat_b;
          frm_g <= sat_g;
          frm_r <= sat_r;
          run_b <= '0;
          run_g <= '0;
          run_r <= '0;
        end else begin
          run_b <= sat_b;
          run_g <= sat_g;
          run_r <= sat_r;
        end
      end
    end
  end

  // Datapath registers of the division sequence and the result register.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        px_b <= pixel_blue;
        px_g <= pixel_green;
        px_r <= pixel_red;
        ch   <= '0;
      end
      ST_TOTAL: begin
        total <= TOT_W'(frm_b) + TOT_W'(frm_g) + TOT_W'(frm_r);
      end
      ST_MUL: begin
        rem      <= NUM_W'(cur_px) * NUM_W'(total);
        den      <= DEN_W'(cur_sum) + DEN_W'({cur_sum, 1'b0});
        dsh      <= {DEN_W'(cur_sum) + DEN_W'({cur_sum, 1'b0}), (QBITS-1)'(0)};
        den_zero <= (cur_sum == '0);
        quo      <= '0;
        step     <= LAST_STEP;
      end
      ST_DIV: begin
        if (unit_ge) rem <= unit_diff[NUM_W-1:0];
        quo  <= {quo[QBITS-2:0], unit_ge};
        dsh  <= dsh >> 1;
        step <= step - STEP_W'(1);
      end
      ST_RND: begin
        case (ch)
          2'd0:    res_b <= ch_res;
          2'd1:    res_g <= ch_res;
          default: res_r <= ch_res;
        endcase
        ch <= ch + CH_W'(1);
      end
      ST_DONE: begin
        if (out_free) begin
          balanced_blue  <= res_b;
          balanced_green <= res_g;
          balanced_red   <= res_r;
        end
      end
      default: begin
        ch <= '0;
      end
    endcase
  end

endmodule

// File: bench/tb.sv
// Self-checking testbench for the gray-world white balance block.
`timescale 1ns / 1ps

module tb;
  import gwwb_pkg::*;

  // One input transaction as the driver sends it.
  typedef struct {
    logic             mode;
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
    logic             frame_end;
  } pixel_item_t;

  // One balanced pixel as the block returns it.
  typedef struct {
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
  } balanced_pixel_t;

  localparam int RANDOM_ITEMS = 1330;
  localparam int PHASE_ITEMS  = 100;
  localparam int DRAIN_CYCLES = 60;
  localparam logic [SUM_W:0] SUM_LIMIT = {1'b0, {SUM_W{1'b1}}};

  logic             clk;
  logic             rst;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic             mode = MODE_GATHER;
  logic [PIX_W-1:0] pixel_blue = '0;
  logic [PIX_W-1:0] pixel_green = '0;
  logic [PIX_W-1:0] pixel_red = '0;
  logic             frame_end = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [PIX_W-1:0] balanced_blue;
  logic [PIX_W-1:0] balanced_green;
  logic [PIX_W-1:0] balanced_red;

  pixel_item_t     pixel_queue[$];
  balanced_pixel_t expected_pixels[$];

  // Predictor state: channel order is blue, green, red.
  logic [SUM_W-1:0] running_sum[3] = '{default: '0};
  logic [SUM_W-1:0] frame_sum[3] = '{default: '0};

  int accepted_items = 0;
  int gather_items = 0;
  int apply_items = 0;
  int frames_latched = 0;
  int pixels_checked = 0;
  int failures = 0;

  gray_world_white_balance_top dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .mode           (mode),
    .pixel_blue     (pixel_blue),
    .pixel_green    (pixel_green),
    .pixel_red      (pixel_red),
    .frame_end      (frame_end),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .balanced_blue  (balanced_blue),
    .balanced_green (balanced_green),
    .balanced_red   (balanced_red)
  );

  // Clock and a single reset at the start of the run.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
  end

  // Idling phase: none, sender gaps, receiver stalls, then both, in turn.
  function automatic int idle_phase();
    return (accepted_items / PHASE_ITEMS) % 4;
  endfunction

  // Exact gain for one channel, rounded half to even and clipped to the pixel range.
  function automatic logic [PIX_W-1:0] gain_channel(input logic [PIX_W-1:0] p,
                                                    input logic [SUM_W+1:0] total,
                                                    input logic [SUM_W-1:0] chan_sum);
    logic [PIX_W+SUM_W+1:0] num;
    logic [SUM_W+1:0]       den;
    logic [PIX_W+SUM_W+1:0] den_w;
    logic [PIX_W+SUM_W+1:0] quo;
    logic [PIX_W+SUM_W+1:0] rem;
    logic [PIX_W+SUM_W+1:0] rem2;
    if (chan_sum == '0) return '0;
    num   = (PIX_W+SUM_W+2)'(p) * (PIX_W+SUM_W+2)'(total);
    den   = (SUM_W+2)'(chan_sum) * (SUM_W+2)'(3);
    den_w = (PIX_W+SUM_W+2)'(den);
    quo   = num / den_w;
    rem   = num % den_w;
    rem2  = rem << 1;
    if (rem2 > den_w || (rem2 == den_w && quo[0])) quo = quo + (PIX_W+SUM_W+2)'(1);
    return (quo > (PIX_W+SUM_W+2)'(PIX_MAX)) ? PIX_MAX : quo[PIX_W-1:0];
  endfunction

  // Update the sums for a gather pixel, or queue the balanced pixel for an apply pixel.
  task automatic predict_pixel(input pixel_item_t it);
    logic [PIX_W-1:0] px[3];
    logic [SUM_W:0]   wide;
    logic [SUM_W+1:0] total;
    balanced_pixel_t  bal;
    px = '{it.blue, it.green, it.red};
    if (it.mode == MODE_GATHER) begin
      gather_items++;
      for (int c = 0; c < 3; c++) begin
        wide = {1'b0, running_sum[c]} + (SUM_W+1)'(px[c]);
        running_sum[c] = (wide > SUM_LIMIT) ? SUM_LIMIT[SUM_W-1:0] : wide[SUM_W-1:0];
      end
      if (it.frame_end) begin
        frames_latched++;
        for (int c = 0; c < 3; c++) begin
          frame_sum[c] = running_sum[c];
          running_sum[c] = '0;
        end
      end
    end else begin
      apply_items++;
      total = (SUM_W+2)'(frame_sum[0]) + (SUM_W+2)'(frame_sum[1]) +
              (SUM_W+2)'(frame_sum[2]);
      bal.blue  = gain_channel(px[0], total, frame_sum[0]);
      bal.green = gain_channel(px[1], total, frame_sum[1]);
      bal.red   = gain_channel(px[2], total, frame_sum[2]);
      expected_pixels.push_back(bal);
    end
  endtask

  task automatic add_item(input logic m, input logic [PIX_W-1:0] b, input logic [PIX_W-1:0] g,
                          input logic [PIX_W-1:0] r, input logic fe);
    pixel_item_t it;
    it.mode = m;
    it.blue = b;
    it.green = g;
    it.red = r;
    it.frame_end = fe;
    pixel_queue.push_back(it);
  endtask

  // Random channel value in a band, now and then pushed to an extreme.
  function automatic logic [PIX_W-1:0] band_value(input int lo, input int hi);
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return PIX_W'(lo);
    if (pick == 1) return PIX_W'(hi);
    return PIX_W'($urandom_range(lo, hi));
  endfunction

  // Driver: records accepted transactions and presents the next pending pixel.
  always @(posedge clk) begin : drive_proc
    pixel_item_t next_item;
    int          phase;
    logic        gap;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        next_item.mode = mode;
        next_item.blue = pixel_blue;
        next_item.green = pixel_green;
        next_item.red = pixel_red;
        next_item.frame_end = frame_end;
        predict_pixel(next_item);
        accepted_items++;
      end
      if (!in_valid || !in_stall) begin
        phase = idle_phase();
        gap = (phase == 1 && $urandom_range(0, 99) < 81) ||
              (phase == 3 && $urandom_range(0, 99) < 25);
        if (pixel_queue.size() != 0 && !gap) begin
          next_item = pixel_queue.pop_front();
          mode        <= next_item.mode;
          pixel_blue  <= next_item.blue;
          pixel_green <= next_item.green;
          pixel_red   <= next_item.red;
          frame_end   <= next_item.frame_end;
          in_valid    <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random output stalls and a field-by-field check of each result.
  always @(posedge clk) begin : check_proc
    balanced_pixel_t want;
    int              phase;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("%0t: unexpected result b=%0d g=%0d r=%0d", $realtime,
                     balanced_blue, balanced_green, balanced_red);
        end else begin
          want = expected_pixels.pop_front();
          pixels_checked++;
          if (balanced_blue !== want.blue || balanced_green !== want.green ||
              balanced_red !== want.red) begin
            failures++;
            if (failures <= 10)
              $display("%0t: mismatch expected b=%0d g=%0d r=%0d, got b=%0d g=%0d r=%0d",
                       $realtime, want.blue, want.green, want.red,
                       balanced_blue, balanced_green, balanced_red);
          end
        end
      end
      phase = idle_phase();
      out_stall <= (phase == 2 && $urandom_range(0, 99) < 81) ||
                   (phase == 3 && $urandom_range(0, 99) < 25);
    end
  end

  // Stimulus, then the wait for the last result and the verdict.
  initial begin : stimulus_proc
    int made;
    int kind;
    int count;
    int lo[3];
    int hi[3];
    int style;

    // Apply before any frame gives zero, also with frame_end set.
    add_item(MODE_APPLY, 8'd255, 8'd255, 8'd255, 1'b0);
    add_item(MODE_APPLY, 8'd0, 8'd0, 8'd0, 1'b1);
    // One-pixel frame with a zero blue sum: the last pixel is added before the latch.
    add_item(MODE_GATHER, 8'd0, 8'd128, 8'd255, 1'b1);
    add_item(MODE_APPLY, 8'd255, 8'd255, 8'd255, 1'b0);
    add_item(MODE_APPLY, 8'd0, 8'd0, 8'd0, 1'b0);
    // Frame whose blue gain is one half, giving exact ties that round to even.
    add_item(MODE_GATHER, 8'd4, 8'd1, 8'd1, 1'b1);
    add_item(MODE_APPLY, 8'd1, 8'd0, 8'd0, 1'b0);
    add_item(MODE_APPLY, 8'd3, 8'd1, 8'd1, 1'b0);
    add_item(MODE_APPLY, 8'd5, 8'd200, 8'd127, 1'b1);
    add_item(MODE_APPLY, 8'd255, 8'd128, 8'd255, 1'b0);
    // A frame spanning several pixels after a cleared running sum.
    add_item(MODE_GATHER, 8'd255, 8'd255, 8'd255, 1'b0);
    add_item(MODE_GATHER, 8'd0, 8'd0, 8'd0, 1'b0);
    add_item(MODE_GATHER, 8'd255, 8'd255, 8'd255, 1'b1);
    add_item(MODE_APPLY, 8'd255, 8'd0, 8'd170, 1'b1);
    add_item(MODE_APPLY, 8'd1, 8'd254, 8'd85, 1'b0);
    // All-zero frame: every channel gives zero.
    add_item(MODE_GATHER, 8'd0, 8'd0, 8'd0, 1'b1);
    add_item(MODE_APPLY, 8'd255, 8'd17, 8'd255, 1'b0);
    // Strongly tinted frame pushes gains into saturation.
    add_item(MODE_GATHER, 8'd1, 8'd255, 8'd255, 1'b1);
    add_item(MODE_APPLY, 8'd255, 8'd255, 8'd255, 1'b0);
    add_item(MODE_APPLY, 8'd2, 8'd100, 8'd0, 1'b1);

    // Random frames with biased channels, each followed by a burst of apply pixels.
    made = 0;
    while (made < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 99);
      if (kind < 75) begin
        for (int c = 0; c < 3; c++) begin
          style = $urandom_range(0, 5);
          case (style)
            0: begin lo[c] = 0; hi[c] = 0; end
            1: begin lo[c] = 0; hi[c] = 255; end
            2: begin lo[c] = 0; hi[c] = 15; end
            3: begin lo[c] = 200; hi[c] = 255; end
            default: begin
              lo[c] = $urandom_range(0, 255);
              hi[c] = $urandom_range(lo[c], 255);
            end
          endcase
        end
        count = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
        for (int i = 0; i < count; i++)
          add_item(MODE_GATHER, band_value(lo[0], hi[0]), band_value(lo[1], hi[1]),
                   band_value(lo[2], hi[2]), i == count - 1);
        made += count;
        count = $urandom_range(1, 8);
        for (int i = 0; i < count; i++)
          add_item(MODE_APPLY, band_value(0, 255), band_value(0, 255), band_value(0, 255),
                   1'($urandom_range(0, 1)));
        made += count;
      end else if (kind < 88) begin
        // Stray apply pixels against the current frame sums.
        count = $urandom_range(1, 4);
        for (int i = 0; i < count; i++)
          add_item(MODE_APPLY, band_value(0, 255), band_value(0, 255), band_value(0, 255),
                   1'($urandom_range(0, 1)));
        made += count;
      end else begin
        // Unterminated gather run that carries into the next frame.
        count = $urandom_range(1, 6);
        for (int i = 0; i < count; i++)
          add_item(MODE_GATHER, band_value(0, 255), band_value(0, 255), band_value(0, 255),
                   1'b0);
        made += count;
      end
    end

    @(negedge clk);
    while (rst || pixel_queue.size() != 0 || in_valid) @(negedge clk);
    while (expected_pixels.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d gather pixels over %0d latched frames and %0d apply pixels.",
             gather_items, frames_latched, apply_items);
    $display("Checked %0d balanced pixels, %0d failures.", pixels_checked, failures);
    if (failures == 0) begin
      $display("gray_world_white_balance_top test passed");
    end else begin
      $display("gray_world_white_balance_top test failed");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #2000000;
    $display("gray_world_white_balance_top test failed");
    $finish;
  end

endmodule
